[design/glyph_quad_text_layout_top_assert.svh]
// Assertion macros for the glyph quad layout block.
`ifndef GLYPH_QUAD_TEXT_LAYOUT_TOP_ASSERT_SVH
`define GLYPH_QUAD_TEXT_LAYOUT_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define GQTL_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("gqtl: assertion failed");
`define GQTL_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("gqtl: reset check failed");
`else
`define GQTL_ASSERT(lbl, prop)
`define GQTL_ASSERT_RST(lbl, prop)
`endif
`endif

[design/gqtl_pkg.sv]
package gqtl_pkg;

    localparam int GLYPH_COUNT = 256;
    localparam int GLYPH_AW    = $clog2(GLYPH_COUNT);
    localparam int POS_FRAC    = 4;
    localparam int POS_W       = 20;
    localparam int ACC_W       = 24;
    localparam int PROD_W      = 32;
    localparam int POS_MAX     = (1 <<< (POS_W - 1)) - 1;
    localparam int POS_MIN     = -(1 <<< (POS_W - 1));

    localparam logic [7:0] CODE_NEWLINE = 8'd10;
    localparam logic [7:0] CODE_SPACE   = 8'd32;

    typedef logic signed [ACC_W-1:0] t_acc;
    typedef logic signed [POS_W-1:0] t_pos;

    typedef enum logic [1:0] {
        KIND_LOAD  = 2'd0,
        KIND_PLACE = 2'd1,
        KIND_END   = 2'd2
    } t_kind;

    typedef enum logic {
        REP_VERTEX = 1'b0,
        REP_SIZE   = 1'b1
    } t_rep_kind;

    typedef enum logic [2:0] {
        CFG_LETTER_SPACING = 3'd0,
        CFG_WORD_SPACING   = 3'd1,
        CFG_LINE_HEIGHT    = 3'd2,
        CFG_WRAP_ENABLE    = 3'd3,
        CFG_MAX_WIDTH      = 3'd4,
        CFG_INV_ATLAS_W    = 3'd5,
        CFG_INV_ATLAS_H    = 3'd6,
        CFG_FONT_SIZE      = 3'd7
    } t_cfg_reg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    typedef struct packed {
        logic [1:0]        kind;
        logic [7:0]        code;
        logic signed [7:0] glyph_left;
        logic signed [7:0] glyph_top;
        logic [7:0]        glyph_width;
        logic [7:0]        glyph_height;
        logic [7:0]        glyph_advance_x;
        logic signed [7:0] glyph_advance_y;
        logic [15:0]       glyph_u;
        logic [15:0]       glyph_v;
    } t_in_word;

    typedef struct packed {
        logic              report_kind;
        logic [15:0]       vertex_index;
        logic signed [19:0] pos_x;
        logic signed [19:0] pos_y;
        logic [15:0]       tex_u;
        logic [15:0]       tex_v;
        logic signed [19:0] content_width;
        logic [15:0]       content_height;
        logic              last;
    } t_out_word;

    typedef struct packed {
        logic signed [7:0] left;
        logic signed [7:0] top;
        logic [7:0]        width;
        logic [7:0]        height;
        logic [7:0]        adv_x;
        logic signed [7:0] adv_y;
        logic [15:0]       u;
        logic [15:0]       v;
    } t_glyph;

    function automatic t_pos sat_pos(input t_acc v);
        t_pos r;
        if (v > t_acc'(POS_MAX)) begin
            r = t_pos'(POS_MAX);
        end else if (v < t_acc'(POS_MIN)) begin
            r = t_pos'(POS_MIN);
        end else begin
            r = v[POS_W-1:0];
        end
        return r;
    endfunction

    // base + round(prod / 256), clamped at full scale
    function automatic logic [15:0] tex_end(input logic [15:0] base,
                                            input logic [PROD_W-1:0] prod);
        logic [PROD_W:0] rnd;
        logic [PROD_W-7:0] t;
        rnd = {1'b0, prod} + (PROD_W+1)'(128);
        t = (PROD_W-6)'(base) + {2'b0, rnd[PROD_W-1:8]};
        return (t > (PROD_W-6)'(16'hFFFF)) ? 16'hFFFF : t[15:0];
    endfunction

endpackage

[design/gqtl_if.sv]
interface gqtl_in_if;
    import gqtl_pkg::*;
    logic     valid;
    logic     ready;
    t_in_word data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface gqtl_out_if;
    import gqtl_pkg::*;
    logic      valid;
    logic      ready;
    t_out_word data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[design/glyph_quad_text_layout_top.sv]
// Glyph quad text layout.
// i_in: one word per load, place or end item. Loads write the glyph table
// (256 entries, single synchronous RAM, registered read), placed characters
// read it, end items close the string.
// o_out: vertex words (four per placed glyph of nonzero size, last on the
// fourth) and one size word per end item.
// i_cfg_we/i_cfg_idx/i_cfg_data: register writes, to be taken only while
// idle; the user must keep to this, the block itself makes no such check.
// A vertex passes the glyph read, step 0 and step 1 of the layout stage,
// the quad buffer and the output register; a size word skips both steps.
// Loads go 1 per cycle while the layout stage is free; the quad buffer paces
// places, handing the output register one vertex a cycle while it is free.
// Reset clears pen, vertex counter, all valids and registers to defaults;
// the glyph table holds garbage until loaded.
// A stalled receiver holds the output register, then the quad buffer,
// then the layout stage, and input ready falls.
module glyph_quad_text_layout_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    gqtl_in_if.sink                           i_in,
    gqtl_out_if.source                        o_out,
    input  logic                              i_cfg_we,
    input  logic [gqtl_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [gqtl_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import gqtl_pkg::*;

    logic signed [11:0] r_cfg_ls;
    logic signed [11:0] r_cfg_ws;
    logic [15:0]        r_cfg_lh;
    logic               r_cfg_wrap;
    logic [18:0]        r_cfg_max_w;
    logic [23:0]        r_cfg_inv_w;
    logic [23:0]        r_cfg_inv_h;
    logic [15:0]        r_cfg_font;

    t_glyph             mem [GLYPH_COUNT];
    t_glyph             r_rd;

    logic               r_s1_valid;
    logic               r_s1_end;
    logic               r_s1_step;
    logic               r_s1_oob;
    logic [7:0]         r_s1_code;

    t_pos               r_w_x0, r_w_x1, r_w_y0, r_w_y1;
    t_pos               r_w_pxa, r_w_pya;
    logic [PROD_W-1:0]  r_w_pu, r_w_pv;
    logic [15:0]        r_w_u0, r_w_v0;
    logic               r_w_emit;

    t_pos               r_pen_x, r_pen_y;
    logic [15:0]        r_vcnt;

    logic               r_q_valid;
    logic               r_q_size;
    logic [1:0]         r_q_k;
    logic [15:0]        r_q_idx;
    t_pos               r_q_x0, r_q_x1, r_q_y0, r_q_y1;
    logic [15:0]        r_q_u0, r_q_u1, r_q_v0, r_q_v1;
    t_pos               r_q_cw;
    logic [15:0]        r_q_ch;

    logic               r_o_valid;
    t_out_word          r_o;

    logic               in_fire;
    logic               in_load, in_work;
    logic               out_free, q_pop, q_pop_last, q_free;
    logic               s1_done, q_load;
    t_glyph             g;
    t_acc               pen_xe, pen_ye, x0_raw, y0_raw;
    logic [15:0]        u1, v1;
    logic               wrap_hit, is_nl, is_sp;
    t_acc               pxa_e, pya_e, lh_e, ws_e;
    t_pos               n_pen_x, n_pen_y, end_cw;
    t_out_word          q_word;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_ls    <= 12'sd16;
            r_cfg_ws    <= 12'sd32;
            r_cfg_lh    <= '0;
            r_cfg_wrap  <= 1'b0;
            r_cfg_max_w <= '0;
            r_cfg_inv_w <= 24'd32768;
            r_cfg_inv_h <= 24'd32768;
            r_cfg_font  <= 16'd256;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                CFG_LETTER_SPACING: r_cfg_ls    <= i_cfg_data[11:0];
                CFG_WORD_SPACING:   r_cfg_ws    <= i_cfg_data[11:0];
                CFG_LINE_HEIGHT:    r_cfg_lh    <= i_cfg_data[15:0];
                CFG_WRAP_ENABLE:    r_cfg_wrap  <= i_cfg_data[0];
                CFG_MAX_WIDTH:      r_cfg_max_w <= i_cfg_data[18:0];
                CFG_INV_ATLAS_W:    r_cfg_inv_w <= i_cfg_data[23:0];
                CFG_INV_ATLAS_H:    r_cfg_inv_h <= i_cfg_data[23:0];
                CFG_FONT_SIZE:      r_cfg_font  <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // handshake and control
    assign out_free   = !r_o_valid || o_out.ready;
    assign q_pop      = r_q_valid && out_free;
    assign q_pop_last = q_pop && (r_q_size || r_q_k == 2'd3);
    assign q_free     = !r_q_valid || q_pop_last;

    assign s1_done = r_s1_valid && (r_s1_end ? q_free
                                   : (r_s1_step && (!r_w_emit || q_free)));
    assign q_load  = s1_done && (r_s1_end || r_w_emit);

    assign i_in.ready = !r_s1_valid || s1_done;
    assign in_fire    = i_in.valid && i_in.ready;
    assign in_load    = in_fire && i_in.data.kind == KIND_LOAD
                        && {1'b0, i_in.data.code} < 9'(GLYPH_COUNT);
    assign in_work    = in_fire && (i_in.data.kind == KIND_PLACE
                                    || i_in.data.kind == KIND_END);

    // glyph table
    always_ff @(posedge i_clk) begin
        if (in_load) begin
            mem[i_in.data.code[GLYPH_AW-1:0]] <= '{
                left:  i_in.data.glyph_left,
                top:   i_in.data.glyph_top,
                width: i_in.data.glyph_width,
                height: i_in.data.glyph_height,
                adv_x: i_in.data.glyph_advance_x,
                adv_y: i_in.data.glyph_advance_y,
                u:     i_in.data.glyph_u,
                v:     i_in.data.glyph_v
            };
        end
        if (in_work) begin
            r_rd <= mem[i_in.data.code[GLYPH_AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s1_step  <= 1'b0;
        end else begin
            if (in_work) begin
                r_s1_valid <= 1'b1;
                r_s1_step  <= 1'b0;
            end else if (s1_done) begin
                r_s1_valid <= 1'b0;
            end else if (r_s1_valid && !r_s1_end) begin
                r_s1_step <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_work) begin
            r_s1_end  <= i_in.data.kind == KIND_END;
            r_s1_code <= i_in.data.code;
            r_s1_oob  <= {1'b0, i_in.data.code} >= 9'(GLYPH_COUNT);
        end
    end

    // step 0: corners, products, pen advance
    always_comb begin
        g      = r_s1_oob ? '0 : r_rd;
        pen_xe = t_acc'(r_pen_x);
        pen_ye = t_acc'(r_pen_y);
        x0_raw = pen_xe + (t_acc'(g.left) <<< POS_FRAC);
        y0_raw = pen_ye + (t_acc'(g.top) <<< POS_FRAC);
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid && !r_s1_end && !r_s1_step) begin
            r_w_x0   <= sat_pos(x0_raw);
            r_w_x1   <= sat_pos(x0_raw + (t_acc'({1'b0, g.width}) <<< POS_FRAC));
            r_w_y0   <= sat_pos(y0_raw);
            r_w_y1   <= sat_pos(y0_raw - (t_acc'({1'b0, g.height}) <<< POS_FRAC));
            r_w_pu   <= PROD_W'(g.width) * PROD_W'(r_cfg_inv_w);
            r_w_pv   <= PROD_W'(g.height) * PROD_W'(r_cfg_inv_h);
            r_w_u0   <= g.u;
            r_w_v0   <= g.v;
            r_w_emit <= g.width != '0 && g.height != '0;
            r_w_pxa  <= sat_pos(pen_xe + (t_acc'({1'b0, g.adv_x}) <<< POS_FRAC)
                                + t_acc'(r_cfg_ls));
            r_w_pya  <= sat_pos(pen_ye + (t_acc'(g.adv_y) <<< POS_FRAC));
        end
    end

    // step 1: texture ends, line breaks, word spacing
    always_comb begin
        u1       = tex_end(r_w_u0, r_w_pu);
        v1       = tex_end(r_w_v0, r_w_pv);
        pxa_e    = t_acc'(r_w_pxa);
        pya_e    = t_acc'(r_w_pya);
        lh_e     = t_acc'({1'b0, r_cfg_lh});
        ws_e     = t_acc'(r_cfg_ws);
        wrap_hit = r_cfg_wrap && (pxa_e >= t_acc'({1'b0, r_cfg_max_w}));
        is_nl    = r_s1_code == CODE_NEWLINE;
        is_sp    = r_s1_code == CODE_SPACE;
        if (wrap_hit && is_nl) begin
            n_pen_y = sat_pos(pya_e - (lh_e <<< 1));
        end else if (wrap_hit || is_nl) begin
            n_pen_y = sat_pos(pya_e - lh_e);
        end else begin
            n_pen_y = r_w_pya;
        end
        if (is_sp) begin
            n_pen_x = wrap_hit ? sat_pos(ws_e) : sat_pos(pxa_e + ws_e);
        end else begin
            n_pen_x = (wrap_hit || is_nl) ? '0 : r_w_pxa;
        end
        end_cw = r_cfg_wrap ? t_pos'({1'b0, r_cfg_max_w}) : r_pen_x;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pen_x <= '0;
            r_pen_y <= '0;
            r_vcnt  <= '0;
        end else if (s1_done) begin
            if (r_s1_end) begin
                r_pen_x <= '0;
                r_pen_y <= '0;
                r_vcnt  <= '0;
            end else begin
                r_pen_x <= n_pen_x;
                r_pen_y <= n_pen_y;
                if (r_w_emit) begin
                    r_vcnt <= r_vcnt + 16'd4;
                end
            end
        end
    end

    // quad buffer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_valid <= 1'b0;
            r_q_k     <= '0;
        end else if (q_load) begin
            r_q_valid <= 1'b1;
            r_q_k     <= '0;
        end else if (q_pop_last) begin
            r_q_valid <= 1'b0;
        end else if (q_pop) begin
            r_q_k <= r_q_k + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (q_load) begin
            r_q_size <= r_s1_end;
            r_q_idx  <= r_vcnt;
            r_q_x0   <= r_w_x0;
            r_q_x1   <= r_w_x1;
            r_q_y0   <= r_w_y0;
            r_q_y1   <= r_w_y1;
            r_q_u0   <= r_w_u0;
            r_q_u1   <= u1;
            r_q_v0   <= r_w_v0;
            r_q_v1   <= v1;
            r_q_cw   <= end_cw;
            r_q_ch   <= r_cfg_font;
        end
    end

    always_comb begin
        q_word = '0;
        if (r_q_size) begin
            q_word.report_kind    = REP_SIZE;
            q_word.content_width  = r_q_cw;
            q_word.content_height = r_q_ch;
            q_word.last           = 1'b1;
        end else begin
            q_word.report_kind  = REP_VERTEX;
            q_word.vertex_index = r_q_idx + 16'(r_q_k);
            q_word.pos_x        = r_q_k[1] ? r_q_x1 : r_q_x0;
            q_word.pos_y        = r_q_k[0] ? r_q_y1 : r_q_y0;
            q_word.tex_u        = r_q_k[1] ? r_q_u1 : r_q_u0;
            q_word.tex_v        = r_q_k[0] ? r_q_v1 : r_q_v0;
            q_word.last         = r_q_k == 2'd3;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (q_pop) begin
            r_o_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (q_pop) begin
            r_o <= q_word;
        end
    end

    assign o_out.valid = r_o_valid;
    assign o_out.data  = r_o;

`include "glyph_quad_text_layout_top_assert.svh"

    `GQTL_ASSERT_RST(a_rst_idle, !i_rst_n |=> !r_o_valid && !r_q_valid && !r_s1_valid)
    `GQTL_ASSERT(a_q_free, q_load |-> !r_q_valid || q_pop_last)
    `GQTL_ASSERT(a_last_idx, r_o_valid && r_o.report_kind == REP_VERTEX |-> r_o.last == (r_o.vertex_index[1:0] == 2'b11))
    `GQTL_ASSERT(a_end_clear, s1_done && r_s1_end |=> r_pen_x == '0 && r_pen_y == '0 && r_vcnt == '0)

endmodule
